### rtl/core/tbh_pkg.sv
// Shared types, constants and helpers for the take-back-half velocity controller.
`default_nettype none

package tbh_pkg;

  localparam int unsigned CMD_W   = 14;
  localparam int unsigned ERR_W   = 18;
  localparam int unsigned AVG_W   = 21;
  localparam int unsigned HOLD_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [HOLD_W-1:0] HOLD_TICKS = 4'd12;
  localparam logic [CMD_W-1:0]  DRIVE_MAX  = 14'd12000;
  localparam logic [CMD_W-1:0]  CMD_RESET  = 14'd1200;
  localparam logic [1:0]        SEL_RESET  = 2'd2;
  localparam logic [1:0]        SEL_HIGH_AUTO = 2'd0;
  localparam logic [1:0]        SEL_MID_AUTO  = 2'd1;
  localparam logic [1:0]        SEL_DRIVER = 2'd2;

  localparam logic [CMD_W-1:0] LEARNED_RESET [3] = '{14'd960, 14'd1100, 14'd1200};

  // divide by 5: ceil(2^26 / 5), exact for dividends below 2^23
  localparam logic [23:0] DIV5_MUL   = 24'd13421773;
  localparam int unsigned DIV5_SHIFT = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SP_HIGH_AUTO  = 3'd0,
    CFG_SP_MID_AUTO   = 3'd1,
    CFG_SP_DRIVER     = 3'd2,
    CFG_INTEGRAL_GAIN = 3'd3,
    CFG_SETTLE_ERR    = 3'd4,
    CFG_SETTLE_SLOPE  = 3'd5,
    CFG_SETTLE_TICKS  = 3'd6,
    CFG_SPIKE_LIMIT   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [14:0] setpoint_high_auto;
    logic [14:0] setpoint_mid_auto;
    logic [14:0] setpoint_driver;
    logic [9:0]  integral_gain;
    logic [15:0] settle_error_limit;
    logic [15:0] settle_slope_limit;
    logic [7:0]  settle_ticks;
    logic [19:0] current_spike_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         setpoint_select;
    logic signed [15:0] filtered_velocity;
    logic [11:0]        motor_current;
  } item_t;

  typedef struct packed {
    logic [CMD_W-1:0] drive_command;
    logic             at_velocity;
    logic             velocity_drop;
    logic             current_spike;
  } res_t;

  typedef struct packed {
    logic              flag;
    logic [HOLD_W-1:0] count;
  } hold_t;

  // flag with a hold: once raised it stays up for HOLD_TICKS ticks
  function automatic hold_t hold_step(input logic [HOLD_W-1:0] count, input logic cond);
    hold_t h;
    if (count != '0 && count < HOLD_TICKS) begin
      h.flag  = 1'b1;
      h.count = count + 1'b1;
    end else if (cond) begin
      h.flag  = 1'b1;
      h.count = HOLD_W'(1);
    end else begin
      h.flag  = 1'b0;
      h.count = '0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tbh_if.sv
// Valid/ready channel interfaces for controller ticks and controller results.
`default_nettype none

interface tbh_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         setpoint_select;
  logic signed [15:0] filtered_velocity;
  logic [11:0]        motor_current;

  modport source (output valid, output setpoint_select, output filtered_velocity,
                  output motor_current, input ready);
  modport sink   (input valid, input setpoint_select, input filtered_velocity,
                  input motor_current, output ready);
endinterface

interface tbh_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] drive_command;
  logic        at_velocity;
  logic        velocity_drop;
  logic        current_spike;

  modport source (output valid, output drive_command, output at_velocity,
                  output velocity_drop, output current_spike, input ready);
  modport sink   (input valid, input drive_command, input at_velocity,
                  input velocity_drop, input current_spike, output ready);
endinterface

`default_nettype wire

### rtl/core/take_back_half_velocity_controller_unit.sv
// Take-back-half flywheel velocity controller, top level.
//
// One input item is one control tick: setpoint selector, filtered velocity
// (Q8 rad/s) and motor current (mA), on in_chan with valid/ready. Each item
// yields exactly one result item on out_chan: drive command (mV, 0..12000),
// at_velocity, velocity_drop and current_spike.
// Path: an accepted item is registered in the input register, evaluated by
// the core and then captured in the result register that drives out_chan.
// Throughput: one item per cycle while out_chan is not stalled; the state update
// (command, take-back value, error history, settle and hold counters, current
// average) is combinational, so items may follow back to back.
// When the receiver stalls, the result register holds and the input register
// keeps one more item; in_chan.ready drops only when both are full.
// Reset (rst_n, synchronous, active low) empties both registers and restores the
// register defaults and controller state. cfg_we/cfg_index/cfg_data write one
// register per cycle; the user must ensure no item is in flight (unenforced).
`default_nettype none

module take_back_half_velocity_controller_unit
  import tbh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tbh_in_if.sink                     in_chan,
  tbh_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  item_t item_r;
  logic  in_valid_r;
  res_t  res;
  res_t  res_r;
  logic  out_valid_r;
  logic  out_load;
  logic  in_ready;

  tbh_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  assign out_load = !out_valid_r || out_chan.ready;
  assign in_ready = !in_valid_r || out_load;

  tbh_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (in_valid_r && out_load),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (out_load) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      item_r.setpoint_select   <= in_chan.setpoint_select;
      item_r.filtered_velocity <= in_chan.filtered_velocity;
      item_r.motor_current     <= in_chan.motor_current;
    end
    if (out_load && in_valid_r) begin
      res_r <= res;
    end
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.drive_command = res_r.drive_command;
  assign out_chan.at_velocity   = res_r.at_velocity;
  assign out_chan.velocity_drop = res_r.velocity_drop;
  assign out_chan.current_spike = res_r.current_spike;

endmodule

`default_nettype wire

### rtl/core/tbh_cfg.sv
// Configuration register file for the controller.
`default_nettype none

module tbh_cfg
  import tbh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  we,
  input  wire logic [CFG_IDX_W-1:0]  index,
  input  wire logic [CFG_DATA_W-1:0] data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint_high_auto  <= 15'd12867;
      cfg_r.setpoint_mid_auto   <= 15'd14742;
      cfg_r.setpoint_driver     <= 15'd16082;
      cfg_r.integral_gain       <= 10'd80;
      cfg_r.settle_error_limit  <= 16'd128;
      cfg_r.settle_slope_limit  <= 16'd12800;
      cfg_r.settle_ticks        <= 8'd10;
      cfg_r.current_spike_limit <= 20'd36;
    end else if (we) begin
      unique case (cfg_idx_t'(index))
        CFG_SP_HIGH_AUTO:  cfg_r.setpoint_high_auto  <= data[14:0];
        CFG_SP_MID_AUTO:   cfg_r.setpoint_mid_auto   <= data[14:0];
        CFG_SP_DRIVER:     cfg_r.setpoint_driver     <= data[14:0];
        CFG_INTEGRAL_GAIN: cfg_r.integral_gain       <= data[9:0];
        CFG_SETTLE_ERR:    cfg_r.settle_error_limit  <= data[15:0];
        CFG_SETTLE_SLOPE:  cfg_r.settle_slope_limit  <= data[15:0];
        CFG_SETTLE_TICKS:  cfg_r.settle_ticks        <= data[7:0];
        CFG_SPIKE_LIMIT:   cfg_r.current_spike_limit <= data[19:0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/core/tbh_core.sv
// Take-back-half update, settle detection, drop and spike flags, and controller state.
`default_nettype none

module tbh_core
  import tbh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  step,
  input  wire item_t item,
  output res_t       res
);

  logic [CMD_W-1:0]        last_cmd_r, last_cmd_nxt;
  logic [CMD_W-1:0]        take_back_r, take_back_nxt;
  logic [CMD_W-1:0]        learned_r [3];
  logic signed [ERR_W-1:0] last_err_r;
  logic [1:0]              last_sel_r;
  logic [7:0]              settled_r, settled_nxt;
  logic [HOLD_W-1:0]       drop_cnt_r;
  logic [HOLD_W-1:0]       spike_cnt_r;
  logic [AVG_W-1:0]        avg_r, avg_nxt;

  logic [1:0]              sel;
  logic                    sel_chg;
  logic [14:0]             target;
  logic [CMD_W-1:0]        tbv;
  logic [15:0]             vel;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] err_neg;
  logic [16:0]             err_abs;
  logic signed [18:0]      dif;
  logic signed [18:0]      dif_neg;
  logic [18:0]             dif_abs;
  logic signed [22:0]      vel_63;
  logic signed [22:0]      tgt_60;
  hold_t                   drop_h;
  hold_t                   spike_h;
  logic [22:0]             avg_sum;
  logic [46:0]             avg_prod;
  logic                    in_band;
  logic [7:0]              need;
  logic                    at_vel;
  logic                    skip;
  logic                    flip;
  logic [CMD_W:0]          tb_sum;
  logic [CMD_W-1:0]        tb;
  logic signed [28:0]      prod;
  logic signed [28:0]      prod_adj;
  logic signed [28:0]      prod_sh;
  logic signed [21:0]      cmd_int;
  logic [CMD_W-1:0]        cmd_integ;

  always_comb begin
    sel = (item.setpoint_select > SEL_DRIVER) ? SEL_DRIVER : item.setpoint_select;
    unique case (sel)
      SEL_HIGH_AUTO: target = cfg.setpoint_high_auto;
      SEL_MID_AUTO:  target = cfg.setpoint_mid_auto;
      default:       target = cfg.setpoint_driver;
    endcase
    sel_chg = sel != last_sel_r;
    tbv     = sel_chg ? learned_r[sel] : take_back_r;

    vel     = item.filtered_velocity;
    err     = $signed({3'b000, target}) - $signed({{2{vel[15]}}, vel});
    err_neg = -err;
    err_abs = err[ERR_W-1] ? err_neg[16:0] : err[16:0];
    dif     = $signed({err[ERR_W-1], err}) - $signed({last_err_r[ERR_W-1], last_err_r});
    dif_neg = -dif;
    dif_abs = dif[18] ? dif_neg : dif;

    // velocity below 60/63 of target
    vel_63 = $signed({{7{vel[15]}}, vel}) * 23'sd63;
    tgt_60 = $signed({8'b0, target}) * 23'sd60;
    drop_h = hold_step(drop_cnt_r, vel_63 < tgt_60);

    // EMA, alpha 0.4: (2*cur*256 + 3*avg) / 5
    avg_sum  = 23'({item.motor_current, 9'b0}) + 23'(avg_r) + 23'({avg_r, 1'b0});
    avg_prod = 47'(avg_sum) * 47'(DIV5_MUL);
    avg_nxt  = avg_prod[DIV5_SHIFT +: AVG_W];
    spike_h  = hold_step(spike_cnt_r, avg_nxt > {1'b0, cfg.current_spike_limit});

    in_band = (err_abs <= {1'b0, cfg.settle_error_limit}) &&
              (dif_abs <= {3'b000, cfg.settle_slope_limit});
    if (!in_band) begin
      settled_nxt = '0;
    end else if (settled_r == 8'hFF) begin
      settled_nxt = settled_r;
    end else begin
      settled_nxt = settled_r + 8'd1;
    end
    need   = (cfg.settle_ticks == '0) ? 8'd1 : cfg.settle_ticks;
    at_vel = in_band && (settled_nxt >= need);
    skip   = at_vel || sel_chg;
    flip   = err[ERR_W-1] != last_err_r[ERR_W-1];

    // both operands already within 0..DRIVE_MAX, so the mean is too
    tb_sum = {1'b0, last_cmd_r} + {1'b0, tbv};
    tb     = tb_sum[CMD_W:1];

    // gain*error/256, truncated toward zero
    prod     = $signed({19'b0, cfg.integral_gain}) * $signed({{11{err[ERR_W-1]}}, err});
    prod_adj = prod + (prod[28] ? 29'sd255 : 29'sd0);
    prod_sh  = prod_adj >>> 8;
    cmd_int  = $signed({8'b0, last_cmd_r}) + $signed(prod_sh[21:0]);
    if (cmd_int[21]) begin
      cmd_integ = '0;
    end else if (cmd_int > $signed({8'b0, DRIVE_MAX})) begin
      cmd_integ = DRIVE_MAX;
    end else begin
      cmd_integ = cmd_int[CMD_W-1:0];
    end

    take_back_nxt = tbv;
    if (skip) begin
      last_cmd_nxt = last_cmd_r;
    end else if (flip) begin
      last_cmd_nxt  = tb;
      take_back_nxt = tb;
    end else begin
      last_cmd_nxt = cmd_integ;
    end

    res.drive_command = last_cmd_nxt;
    res.at_velocity   = at_vel;
    res.velocity_drop = drop_h.flag;
    res.current_spike = spike_h.flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cmd_r   <= CMD_RESET;
      take_back_r  <= CMD_RESET;
      learned_r    <= LEARNED_RESET;
      last_err_r   <= '0;
      last_sel_r   <= SEL_RESET;
      settled_r    <= '0;
      drop_cnt_r   <= '0;
      spike_cnt_r  <= '0;
      avg_r        <= '0;
    end else if (step) begin
      last_cmd_r  <= last_cmd_nxt;
      take_back_r <= take_back_nxt;
      if (!skip && flip) begin
        learned_r[sel] <= tb;
      end
      last_err_r  <= err;
      last_sel_r  <= sel;
      settled_r   <= settled_nxt;
      drop_cnt_r  <= drop_h.count;
      spike_cnt_r <= spike_h.count;
      avg_r       <= avg_nxt;
    end
  end

endmodule

`default_nettype wire
